FILE: rtl/core/hbr_pkg.sv
// shared constants, types and codes for the hid boot report event decoder
`default_nettype none

package hbr_pkg;

   localparam int KEY_SLOTS   = 6;
   localparam int FIELD_SLOTS = 6;
   localparam int PAY_BYTES   = 8;
   localparam int NUM_MODS    = 8;
   localparam int NUM_BUTTONS = 5;
   // modifiers, a release and a press per slot, and the closing sync
   localparam int NUM_EVENTS  = NUM_MODS + 2 * KEY_SLOTS + 1;
   localparam int EV_IDX_W    = $clog2(NUM_EVENTS);

   localparam logic [7:0] ID_KEYBOARD    = 8'h01;
   localparam logic [7:0] ID_MOUSE       = 8'h02;
   localparam logic [7:0] USAGE_ROLLOVER = 8'h01;
   localparam logic [7:0] USAGE_MAX_RSVD = 8'd3;
   localparam logic [7:0] MOD_BASE       = 8'd224;
   localparam logic [3:0] WHEEL_MIN_LEN  = 4'd3;

   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_BUTTON = 2'd1;
   localparam logic [1:0] KIND_AXIS   = 2'd2;
   localparam logic [1:0] KIND_SYNC   = 2'd3;

   localparam logic [7:0] AXIS_X     = 8'd0;
   localparam logic [7:0] AXIS_Y     = 8'd1;
   localparam logic [7:0] AXIS_WHEEL = 8'd2;

   typedef logic [7:0] usage_type;
   typedef usage_type [KEY_SLOTS-1:0] slots_type;
   typedef logic [PAY_BYTES-1:0][7:0] pay_type;

   typedef struct packed {
      logic key_up;
      logic key_down;
   } lane_flags_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code;
      logic [7:0] value;
   } event_type;

   typedef event_type [NUM_EVENTS-1:0] event_list_type;

endpackage

`default_nettype wire

FILE: rtl/core/hbr_if.sv
// request and response channel interfaces of the hid boot report event decoder
`default_nettype none

interface hbr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_id;
   logic [3:0] payload_length;
   logic [7:0] pay0;
   logic [7:0] pay1;
   logic [7:0] pay2;
   logic [7:0] pay3;
   logic [7:0] pay4;
   logic [7:0] pay5;
   logic [7:0] pay6;
   logic [7:0] pay7;

   modport source (
      output valid, report_id, payload_length, pay0, pay1, pay2, pay3, pay4, pay5,
             pay6, pay7,
      input  ready
   );
   modport sink (
      input  valid, report_id, payload_length, pay0, pay1, pay2, pay3, pay4, pay5,
             pay6, pay7,
      output ready
   );
endinterface

interface hbr_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        event_kind;
   logic [7:0]        event_code;
   logic signed [7:0] event_value;
   logic              last_event;

   modport source (
      output valid, event_kind, event_code, event_value, last_event,
      input  ready
   );
   modport sink (
      input  valid, event_kind, event_code, event_value, last_event,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/hbr_lane.sv
// one key slot lane: finds whether the old usage is released and the new one pressed
`default_nettype none

module hbr_lane (
   input  wire hbr_pkg::usage_type      old_usage,
   input  wire hbr_pkg::usage_type      new_usage,
   input  wire hbr_pkg::slots_type      fresh,
   input  wire hbr_pkg::slots_type      held,
   output hbr_pkg::lane_flags_type      flags
);

   logic old_kept;
   logic new_known;

   always_comb begin
      old_kept  = 1'b0;
      new_known = 1'b0;
      for (int i = 0; i < hbr_pkg::KEY_SLOTS; i++) begin
         if (fresh[i] == old_usage) old_kept = 1'b1;
         if (held[i] == new_usage)  new_known = 1'b1;
      end
      flags.key_up   = (old_usage > hbr_pkg::USAGE_MAX_RSVD) && !old_kept;
      flags.key_down = (new_usage > hbr_pkg::USAGE_MAX_RSVD) && !new_known;
   end

endmodule

`default_nettype wire

FILE: rtl/core/hbr_merge.sv
// slot lanes plus the merge that lays out one request's events and the new held slots
`default_nettype none

module hbr_merge (
   input  wire [7:0]                    report_id,
   input  wire [3:0]                    payload_length,
   input  wire hbr_pkg::pay_type        pay,
   input  wire hbr_pkg::slots_type      held,
   output hbr_pkg::event_list_type      events,
   output logic [hbr_pkg::NUM_EVENTS-1:0] mask,
   output logic                         held_load,
   output hbr_pkg::slots_type           fresh
);

   hbr_pkg::lane_flags_type [hbr_pkg::KEY_SLOTS-1:0] flags;
   logic rollover;

   // slots beyond the payload fields read as zero
   for (genvar s = 0; s < hbr_pkg::KEY_SLOTS; s++) begin : g_lane
      if (s < hbr_pkg::FIELD_SLOTS) begin : g_field
         assign fresh[s] = pay[s + 2];
      end else begin : g_zero
         assign fresh[s] = '0;
      end

      hbr_lane u_lane (
         .old_usage (held[s]),
         .new_usage (fresh[s]),
         .fresh     (fresh),
         .held      (held),
         .flags     (flags[s])
      );
   end

   always_comb begin
      rollover = 1'b1;
      for (int s = 0; s < hbr_pkg::KEY_SLOTS; s++) begin
         if (fresh[s] != hbr_pkg::USAGE_ROLLOVER) rollover = 1'b0;
      end
   end

   always_comb begin
      events    = '0;
      mask      = '0;
      held_load = 1'b0;
      if (report_id == hbr_pkg::ID_KEYBOARD) begin
         for (int m = 0; m < hbr_pkg::NUM_MODS; m++) begin
            events[m].kind  = hbr_pkg::KIND_KEY;
            events[m].code  = hbr_pkg::MOD_BASE + 8'(m);
            events[m].value = {7'd0, pay[0][m]};
            mask[m]         = 1'b1;
         end
         if (!rollover) begin
            held_load = 1'b1;
            for (int s = 0; s < hbr_pkg::KEY_SLOTS; s++) begin
               events[hbr_pkg::NUM_MODS + 2*s].kind      = hbr_pkg::KIND_KEY;
               events[hbr_pkg::NUM_MODS + 2*s].code      = held[s];
               events[hbr_pkg::NUM_MODS + 2*s].value     = 8'd0;
               mask[hbr_pkg::NUM_MODS + 2*s]             = flags[s].key_up;
               events[hbr_pkg::NUM_MODS + 2*s + 1].kind  = hbr_pkg::KIND_KEY;
               events[hbr_pkg::NUM_MODS + 2*s + 1].code  = fresh[s];
               events[hbr_pkg::NUM_MODS + 2*s + 1].value = 8'd1;
               mask[hbr_pkg::NUM_MODS + 2*s + 1]         = flags[s].key_down;
            end
         end
      end else if (report_id == hbr_pkg::ID_MOUSE) begin
         for (int b = 0; b < hbr_pkg::NUM_BUTTONS; b++) begin
            events[b].kind  = hbr_pkg::KIND_BUTTON;
            events[b].code  = 8'(b);
            events[b].value = {7'd0, pay[0][b]};
            mask[b]         = 1'b1;
         end
         events[hbr_pkg::NUM_BUTTONS]     = '{hbr_pkg::KIND_AXIS, hbr_pkg::AXIS_X, pay[1]};
         events[hbr_pkg::NUM_BUTTONS + 1] = '{hbr_pkg::KIND_AXIS, hbr_pkg::AXIS_Y, pay[2]};
         events[hbr_pkg::NUM_BUTTONS + 2] =
            '{hbr_pkg::KIND_AXIS, hbr_pkg::AXIS_WHEEL, pay[3]};
         mask[hbr_pkg::NUM_BUTTONS]       = 1'b1;
         mask[hbr_pkg::NUM_BUTTONS + 1]   = 1'b1;
         mask[hbr_pkg::NUM_BUTTONS + 2]   = payload_length > hbr_pkg::WHEEL_MIN_LEN;
      end
      events[hbr_pkg::NUM_EVENTS-1] = '{hbr_pkg::KIND_SYNC, 8'd0, 8'd0};
      mask[hbr_pkg::NUM_EVENTS-1]   = 1'b1;
   end

endmodule

`default_nettype wire

FILE: rtl/core/hid_boot_report_event_decoder.sv
// top level: boot report to input event decoder with slot lanes and an event sequencer
//
//   channel    direction  carries
//   req_chan   in         one boot report: id, payload length, eight payload bytes
//   rsp_chan   out        one input event: kind, code, value, last flag
//
// a request with n events (1 to 21) occupies the sequencer, one event a cycle into the
// output register; the next request is taken in the cycle the previous one's final
// (sync) event moves out, so reports follow back to back. the slot lanes compare
// against the held slots in the accept cycle and the held slots update at that edge
// (keyboard, no rollover). synchronous reset clears the held slots, sequencer and
// output register. a stalled rsp_chan holds the sequencer and then req_chan.
`default_nettype none

module hid_boot_report_event_decoder (
   input  wire     clock,
   input  wire     reset,
   hbr_req_if.sink   req_chan,
   hbr_rsp_if.source rsp_chan
);

   hbr_pkg::slots_type                 held_ff,      held_in;
   logic [hbr_pkg::NUM_EVENTS-1:0]     job_mask_ff,  job_mask_in;
   hbr_pkg::event_list_type            job_events_ff, job_events_in;
   logic                               out_valid_ff, out_valid_in;
   hbr_pkg::event_type                 out_event_ff, out_event_in;

   hbr_pkg::pay_type                   pay;
   hbr_pkg::event_list_type            new_events;
   logic [hbr_pkg::NUM_EVENTS-1:0]     new_mask;
   logic                               held_load;
   hbr_pkg::slots_type                 fresh;

   logic [hbr_pkg::NUM_EVENTS-1:0]     mask_after;
   logic [hbr_pkg::EV_IDX_W-1:0]       ev_idx;
   logic                               job_busy;
   logic                               out_free;
   logic                               step;
   logic                               accept;

   assign pay = {req_chan.pay7, req_chan.pay6, req_chan.pay5, req_chan.pay4,
                 req_chan.pay3, req_chan.pay2, req_chan.pay1, req_chan.pay0};

   hbr_merge u_merge (
      .report_id      (req_chan.report_id),
      .payload_length (req_chan.payload_length),
      .pay            (pay),
      .held           (held_ff),
      .events         (new_events),
      .mask           (new_mask),
      .held_load      (held_load),
      .fresh          (fresh)
   );

   // lowest pending event goes next
   always_comb begin
      ev_idx = '0;
      for (int i = hbr_pkg::NUM_EVENTS - 1; i >= 0; i--) begin
         if (job_mask_ff[i]) ev_idx = hbr_pkg::EV_IDX_W'(i);
      end
   end

   assign mask_after = job_mask_ff & (job_mask_ff - 1'b1);
   assign job_busy   = |job_mask_ff;
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign step       = job_busy && out_free;
   assign req_chan.ready = !job_busy || (step && (mask_after == '0));
   assign accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      job_mask_in   = job_mask_ff;
      job_events_in = job_events_ff;
      held_in       = held_ff;
      if (step) job_mask_in = mask_after;
      if (accept) begin
         job_mask_in   = new_mask;
         job_events_in = new_events;
         if (held_load) held_in = fresh;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_event_in = out_event_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_event_in = job_events_ff[ev_idx];
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         job_mask_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         job_mask_ff  <= job_mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_events_ff <= job_events_in;
      out_event_ff  <= out_event_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.event_kind  = out_event_ff.kind;
   assign rsp_chan.event_code  = out_event_ff.code;
   assign rsp_chan.event_value = $signed(out_event_ff.value);
   assign rsp_chan.last_event  = (out_event_ff.kind == hbr_pkg::KIND_SYNC);

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the hid boot report event decoder
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   typedef struct {
      logic [7:0]       id;
      logic [3:0]       len;
      hbr_pkg::pay_type pay;
   } boot_report_type;

   typedef struct {
      logic [1:0]        kind;
      logic [7:0]        code;
      logic signed [7:0] value;
      logic              last;
   } input_event_type;

   logic clock;
   logic reset;

   hbr_req_if req_ch ();
   hbr_rsp_if rsp_ch ();

   hid_boot_report_event_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_ch),
      .rsp_chan (rsp_ch)
   );

   input_event_type    pending_events[$];
   hbr_pkg::slots_type held_slots;
   bit                 idle_on;
   int                 mismatch_count;
   int                 reports_sent;
   int                 events_checked;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit slots_hold(input hbr_pkg::slots_type slots,
                                     input hbr_pkg::usage_type usage);
      for (int i = 0; i < hbr_pkg::KEY_SLOTS; i++)
         if (slots[i] == usage)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic void push_event(input logic [1:0] kind, input logic [7:0] code,
                                      input logic [7:0] value, input logic last);
      input_event_type ev;
      ev.kind  = kind;
      ev.code  = code;
      ev.value = value;
      ev.last  = last;
      pending_events.push_back(ev);
   endfunction

   function automatic void decode_report(input boot_report_type r);
      hbr_pkg::slots_type fresh;
      bit                 rollover;
      hbr_pkg::usage_type old_u;
      hbr_pkg::usage_type new_u;
      if (r.id == hbr_pkg::ID_KEYBOARD) begin
         for (int i = 0; i < hbr_pkg::NUM_MODS; i++)
            push_event(hbr_pkg::KIND_KEY, 8'(hbr_pkg::MOD_BASE + i),
                       {7'd0, r.pay[0][i]}, 1'b0);
         rollover = 1'b1;
         for (int i = 0; i < hbr_pkg::KEY_SLOTS; i++) begin
            fresh[i] = (i < hbr_pkg::FIELD_SLOTS) ? r.pay[2 + i] : 8'd0;
            if (fresh[i] != hbr_pkg::USAGE_ROLLOVER)
               rollover = 1'b0;
         end
         // rollover leaves the held slots alone
         if (!rollover) begin
            for (int i = 0; i < hbr_pkg::KEY_SLOTS; i++) begin
               old_u = held_slots[i];
               new_u = fresh[i];
               if (old_u > hbr_pkg::USAGE_MAX_RSVD && !slots_hold(fresh, old_u))
                  push_event(hbr_pkg::KIND_KEY, old_u, 8'd0, 1'b0);
               if (new_u > hbr_pkg::USAGE_MAX_RSVD && !slots_hold(held_slots, new_u))
                  push_event(hbr_pkg::KIND_KEY, new_u, 8'd1, 1'b0);
            end
            held_slots = fresh;
         end
      end else if (r.id == hbr_pkg::ID_MOUSE) begin
         for (int i = 0; i < hbr_pkg::NUM_BUTTONS; i++)
            push_event(hbr_pkg::KIND_BUTTON, 8'(i), {7'd0, r.pay[0][i]}, 1'b0);
         push_event(hbr_pkg::KIND_AXIS, hbr_pkg::AXIS_X, r.pay[1], 1'b0);
         push_event(hbr_pkg::KIND_AXIS, hbr_pkg::AXIS_Y, r.pay[2], 1'b0);
         if (r.len > hbr_pkg::WHEEL_MIN_LEN)
            push_event(hbr_pkg::KIND_AXIS, hbr_pkg::AXIS_WHEEL, r.pay[3], 1'b0);
      end
      push_event(hbr_pkg::KIND_SYNC, 8'd0, 8'd0, 1'b1);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic boot_report_type make_report(input logic [7:0] id,
                                                   input logic [3:0] len,
                                                   input logic [7:0] p0, p1, p2, p3,
                                                   input logic [7:0] p4, p5, p6, p7);
      boot_report_type r;
      r.id  = id;
      r.len = len;
      r.pay = {p7, p6, p5, p4, p3, p2, p1, p0};
      return r;
   endfunction

   // valid stays high from one request to the next unless a gap is drawn
   task automatic send_report(input boot_report_type r);
      if (idle_on)
         while ($urandom_range(0, 99) < 10) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      req_ch.valid          <= 1'b1;
      req_ch.report_id      <= r.id;
      req_ch.payload_length <= r.len;
      req_ch.pay0           <= r.pay[0];
      req_ch.pay1           <= r.pay[1];
      req_ch.pay2           <= r.pay[2];
      req_ch.pay3           <= r.pay[3];
      req_ch.pay4           <= r.pay[4];
      req_ch.pay5           <= r.pay[5];
      req_ch.pay6           <= r.pay[6];
      req_ch.pay7           <= r.pay[7];
      do
         @(posedge clock);
      while (!req_ch.ready);
      decode_report(r);
      reports_sent++;
   endtask

   function automatic boot_report_type random_report();
      boot_report_type r;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         r.id = hbr_pkg::ID_KEYBOARD;
      else if (pick < 85)
         r.id = hbr_pkg::ID_MOUSE;
      else
         r.id = 8'($urandom);
      r.len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
      for (int i = 0; i < hbr_pkg::PAY_BYTES; i++)
         r.pay[i] = 8'($urandom);
      return r;
   endfunction

   task automatic test_keyboard_directed();
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'hFF, 8'hFF, 8'h04, 8'h05,
                              8'h06, 8'h07, 8'h08, 8'h09));
      // some kept, some released, some new
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'hA5, 8'h00, 8'h04, 8'h05,
                              8'h0A, 8'h0B, 8'h00, 8'h00));
      // rollover: modifiers only
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'h5A, 8'h00, 8'h01, 8'h01,
                              8'h01, 8'h01, 8'h01, 8'h01));
      // held keys moved to other slots give no events
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'h00, 8'h00, 8'h05, 8'h04,
                              8'h00, 8'h00, 8'h00, 8'h00));
      // reserved usages and a duplicate of a held key
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'h01, 8'h00, 8'h01, 8'h02,
                              8'h03, 8'h00, 8'h04, 8'h04));
      // duplicate new usage and the top codes
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'h80, 8'h55, 8'hFF, 8'hFF,
                              8'hE0, 8'h80, 8'h7F, 8'h10));
      // nearly a rollover pattern
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'h00, 8'h00, 8'h01, 8'h01,
                              8'h01, 8'h01, 8'h01, 8'h00));
      // the length does not limit the key slots
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd0, 8'h02, 8'h00, 8'h04, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h2C));
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd15, 8'h40, 8'hAA, 8'h00, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h2D));
   endtask

   task automatic test_mouse_directed();
      send_report(make_report(hbr_pkg::ID_MOUSE, 4'd3, 8'h1F, 8'h7F, 8'h80, 8'h55,
                              8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(hbr_pkg::ID_MOUSE, 4'd4, 8'hE0, 8'h80, 8'h7F, 8'h80,
                              8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(hbr_pkg::ID_MOUSE, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_report(make_report(hbr_pkg::ID_MOUSE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(hbr_pkg::ID_MOUSE, 4'd15, 8'h0A, 8'h01, 8'hFE, 8'h01,
                              8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_unknown_ids();
      send_report(make_report(8'h00, 4'd8, 8'hFF, 8'h00, 8'h04, 8'h05,
                              8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h03, 4'd4, 8'h1F, 8'h10, 8'h10, 8'h10,
                              8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'hFF, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_report(make_report(8'h81, 4'd8, 8'hFF, 8'h00, 8'h06, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h00));
      // release everything still held
      send_report(make_report(hbr_pkg::ID_KEYBOARD, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // typing sessions: keys held over several reports, a small pool of usages
   task automatic test_random_typing(input int count);
      hbr_pkg::slots_type typed;
      boot_report_type    r;
      int                 pick;
      typed = '0;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < hbr_pkg::KEY_SLOTS; i++)
               typed[i] = hbr_pkg::USAGE_ROLLOVER;
         end else begin
            for (int i = 0; i < hbr_pkg::KEY_SLOTS; i++) begin
               pick = $urandom_range(0, 99);
               if (typed[i] == hbr_pkg::USAGE_ROLLOVER || pick < 15)
                  typed[i] = 8'($urandom_range(4, 12));
               else if (pick < 30)
                  typed[i] = 8'd0;
               else if (pick < 38)
                  typed[i] = 8'($urandom);
               else if (pick < 45)
                  typed[i] = 8'($urandom_range(0, 3));
            end
         end
         r.id  = hbr_pkg::ID_KEYBOARD;
         r.len = 4'($urandom_range(0, 15));
         r.pay[0] = 8'($urandom);
         r.pay[1] = 8'($urandom);
         for (int i = 0; i < hbr_pkg::FIELD_SLOTS; i++)
            r.pay[2 + i] = typed[i];
         // an occasional stray report from another device
         if ($urandom_range(0, 9) == 0)
            send_report(random_report());
         send_report(r);
      end
   endtask

   task automatic test_random_mixed(input int count);
      for (int n = 0; n < count; n++)
         send_report(random_report());
   endtask

   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      test_random_mixed(count);
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : event_check
      input_event_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: event with nothing expected: kind %0d code %h value %h last %b",
                     $time, rsp_ch.event_kind, rsp_ch.event_code, rsp_ch.event_value,
                     rsp_ch.last_event);
            mismatch_count++;
         end else begin
            want = pending_events.pop_front();
            events_checked++;
            if (rsp_ch.event_kind !== want.kind) begin
               $display("%0t: event_kind expected %0d actual %0d",
                        $time, want.kind, rsp_ch.event_kind);
               mismatch_count++;
            end
            if (rsp_ch.event_code !== want.code) begin
               $display("%0t: event_code expected %h actual %h",
                        $time, want.code, rsp_ch.event_code);
               mismatch_count++;
            end
            if (rsp_ch.event_value !== want.value) begin
               $display("%0t: event_value expected %h actual %h",
                        $time, want.value, rsp_ch.event_value);
               mismatch_count++;
            end
            if (rsp_ch.last_event !== want.last) begin
               $display("%0t: last_event expected %b actual %b",
                        $time, want.last, rsp_ch.last_event);
               mismatch_count++;
            end
         end
      end
      if (reset)
         rsp_ch.ready <= 1'b0;
      else if (idle_on)
         rsp_ch.ready <= ($urandom_range(0, 99) >= 10);
      else
         rsp_ch.ready <= 1'b1;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int drain_cycles;
      idle_on        = 1'b1;
      mismatch_count = 0;
      reports_sent   = 0;
      events_checked = 0;
      held_slots     = '0;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.report_id      <= 8'd0;
      req_ch.payload_length <= 4'd0;
      req_ch.pay0           <= 8'd0;
      req_ch.pay1           <= 8'd0;
      req_ch.pay2           <= 8'd0;
      req_ch.pay3           <= 8'd0;
      req_ch.pay4           <= 8'd0;
      req_ch.pay5           <= 8'd0;
      req_ch.pay6           <= 8'd0;
      req_ch.pay7           <= 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_keyboard_directed();
      test_mouse_directed();
      test_unknown_ids();
      test_random_typing(140);
      test_back_to_back(60);
      test_random_mixed(140);

      req_ch.valid <= 1'b0;
      drain_cycles = 0;
      while (pending_events.size() != 0 && drain_cycles < 20_000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_events.size() != 0) begin
         $display("%0t: %0d events never arrived", $time, pending_events.size());
         mismatch_count++;
      end
      // catch any stray events after the last expected one
      repeat (2 * hbr_pkg::NUM_EVENTS + 8) @(posedge clock);

      $display("covered %0d reports (keyboard, mouse, unknown ids, rollover, typing runs)",
               reports_sent);
      $display("checked %0d events, %0d mismatches", events_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
